[hw/rtl/byte_ring_fifo_top_assert.svh]
// ----------------------------------------------------------------------------
// byte ring fifo assertion macros
// concurrent assertion shorthands, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_TOP_ASSERT_SVH

// same-cycle implication
`define BRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// types and constants shared by the byte ring fifo
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int CSR_WIDTH     = 9;

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_REMOVE     = 2'd1,
      CMD_DMA_REMOVE = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_RESULT = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] byte_in;
      logic [8:0] remaining_count;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic       success;
      logic       stored;
   } rsp_type;

endpackage

[hw/rtl/brf_ram.sv]
// ----------------------------------------------------------------------------
// brf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/byte_ring_fifo_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_top
// byte ring fifo over a configurable part of a ram, one slot kept free;
// add, remove, dma remove with head reload, and clear
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_     | in        | brf_pkg::req_type (cmd, byte_in, remaining_count)
//  rsp_     | out       | brf_pkg::rsp_type (byte_out, success, stored)
//  csr_     | in        | used capacity, 9 bits; also zeroes both indices
//
// the accept cycle of a request updates the indices and issues the ram access,
// and the result state then moves the result into the output register.
// a stalled output register holds the block in its result cycle.
// one request in flight, so a read never meets a pending write to its slot.
// synchronous reset clears indices, state and valid and sets the capacity to the
// smaller of the depth and 256; the ram is not cleared.
module byte_ring_fifo_top #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  brf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output brf_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [brf_pkg::CSR_WIDTH-1:0]  csr_data
);

   localparam int AW = $clog2(DEPTH);
   // wide enough for the depth itself and for the 9-bit capacity and count
   localparam int IW = (AW + 1 > brf_pkg::CSR_WIDTH + 1) ? AW + 1 : brf_pkg::CSR_WIDTH + 1;
   localparam logic [IW-1:0] DEPTH_W   = IW'(DEPTH);
   localparam logic [IW-1:0] CAP_MIN   = IW'(2);
   localparam logic [IW-1:0] CAP_RESET = (DEPTH < 256) ? IW'(DEPTH) : IW'(256);

   brf_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      cap_ff, cap_in;
   logic [AW-1:0]      wr_idx_ff, wr_idx_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   brf_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               res_removed_ff, res_removed_in;
   logic               res_success_ff, res_success_in;
   logic               res_stored_ff, res_stored_in;

   logic               req_fire;
   logic               csr_fire;
   logic               ram_wr_en;
   logic [7:0]         ram_rd_data;
   logic [IW-1:0]      wr_ext;
   logic [IW-1:0]      rd_ext;
   logic [IW-1:0]      wr_next;
   logic [IW-1:0]      wr_next2;
   logic [IW-1:0]      rd_next;
   logic [IW-1:0]      csr_ext;
   logic [IW-1:0]      cnt_ext;
   logic [IW-1:0]      cnt_clamp;
   logic [IW-1:0]      dma_head;

   function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                             input logic [IW-1:0] cap);
      logic [IW-1:0] n;
      n = idx + IW'(1);
      return (n >= cap) ? '0 : n;
   endfunction

   assign req_ready = (state_ff == brf_pkg::ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == brf_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign wr_ext    = IW'(wr_idx_ff);
   assign rd_ext    = IW'(rd_idx_ff);
   assign wr_next   = advance(wr_ext, cap_ff);
   assign wr_next2  = advance(wr_next, cap_ff);
   assign rd_next   = advance(rd_ext, cap_ff);
   assign csr_ext   = IW'(csr_data);
   assign cnt_ext   = IW'(req_data.remaining_count);
   assign cnt_clamp = (cnt_ext > cap_ff) ? cap_ff : cnt_ext;
   // a zero count would put the head on the capacity, which wraps to 0
   assign dma_head  = (cnt_clamp == '0) ? '0 : cap_ff - cnt_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brf_pkg::ST_IDLE;
         cap_ff       <= CAP_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         wr_idx_ff    <= wr_idx_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff    <= rsp_data_in;
      res_removed_ff <= res_removed_in;
      res_success_ff <= res_success_in;
      res_stored_ff  <= res_stored_in;
   end

   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      wr_idx_in      = wr_idx_ff;
      rd_idx_in      = rd_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      res_removed_in = res_removed_ff;
      res_success_in = res_success_ff;
      res_stored_in  = res_stored_ff;
      ram_wr_en      = 1'b0;

      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (csr_fire) begin
               if (csr_ext < CAP_MIN) begin
                  cap_in = CAP_MIN;
               end else if (csr_ext > DEPTH_W) begin
                  cap_in = DEPTH_W;
               end else begin
                  cap_in = csr_ext;
               end
               wr_idx_in = '0;
               rd_idx_in = '0;
            end else if (req_fire) begin
               res_removed_in = 1'b0;
               res_success_in = 1'b0;
               res_stored_in  = 1'b0;
               state_in       = brf_pkg::ST_RESULT;
               case (req_data.cmd)
                  brf_pkg::CMD_ADD: begin
                     if (wr_next != rd_ext) begin
                        ram_wr_en      = 1'b1;
                        wr_idx_in      = AW'(wr_next);
                        res_stored_in  = 1'b1;
                        res_success_in = (wr_next2 != rd_ext);
                     end
                  end
                  brf_pkg::CMD_REMOVE: begin
                     if (rd_ext != wr_ext) begin
                        rd_idx_in      = AW'(rd_next);
                        res_removed_in = 1'b1;
                        res_success_in = 1'b1;
                     end
                  end
                  brf_pkg::CMD_DMA_REMOVE: begin
                     wr_idx_in = AW'(dma_head);
                     if (rd_ext != dma_head) begin
                        rd_idx_in      = AW'(rd_next);
                        res_removed_in = 1'b1;
                        res_success_in = 1'b1;
                     end
                  end
                  brf_pkg::CMD_CLEAR: begin
                     rd_idx_in = wr_idx_ff;
                  end
                  default: begin
                     rd_idx_in = rd_idx_ff;
                  end
               endcase
            end
         end
         brf_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.byte_out = res_removed_ff ? ram_rd_data : 8'd0;
               rsp_data_in.success  = res_success_ff;
               rsp_data_in.stored   = res_stored_ff;
               state_in             = brf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase
   end

   brf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (req_data.byte_in),
      .rd_en   (req_fire),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

endmodule

[hw/rtl/brf_checker.sv]
// ----------------------------------------------------------------------------
// brf_checker
// port-level checks of the byte ring fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_top_assert.svh"

module brf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input brf_pkg::req_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input brf_pkg::rsp_type              rsp_data,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [brf_pkg::CSR_WIDTH-1:0] csr_data
);

   logic rsp_stall;
   logic req_taken;
   logic rsp_add;
   logic rsp_fail;
   logic byte_zero;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_taken = req_valid && req_ready;
   assign rsp_add   = rsp_valid && rsp_data.stored;
   assign rsp_fail  = rsp_valid && !rsp_data.success;
   assign byte_zero = (rsp_data.byte_out == 8'd0);

   // a stalled response keeps its payload
   `BRF_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "response not held")

   // one request in flight: the cycle after an accept takes nothing
   `BRF_ASSERT_NEXT(a_one_in_flight, req_taken, !req_ready && !csr_ready, "overlapping request")

   // an add never returns a byte
   `BRF_ASSERT_SAME(a_add_no_byte, rsp_add, byte_zero, "add returned a byte")

   // a failed command returns no byte
   `BRF_ASSERT_SAME(a_fail_no_byte, rsp_fail, byte_zero, "byte returned without success")

endmodule

bind byte_ring_fifo_top brf_checker u_brf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
